// ===== rtl/core/mdsl_pkg.sv =====
`default_nettype none
package mdsl_pkg;

  localparam int MAX_WINDOW = 16;
  localparam int WIN_IDX_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int LEN_W      = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W      = 16 + WIN_IDX_W;

  // shared serial divider: 31-bit dividend, 15-bit divisor
  localparam int DIV_W      = 31;
  localparam int DVS_W      = 15;
  localparam int DIV_CNT_W  = $clog2(DIV_W);

  localparam logic [1:0] KIND_CMD     = 2'd0;
  localparam logic [1:0] KIND_FILTER  = 2'd1;
  localparam logic [1:0] KIND_PUBLISH = 2'd2;

  localparam logic [2:0] CFG_WINDOW_LENGTH  = 3'd0;
  localparam logic [2:0] CFG_MAX_VELOCITY   = 3'd1;
  localparam logic [2:0] CFG_DUTY_LIMIT     = 3'd2;
  localparam logic [2:0] CFG_DUTY_DEADBAND  = 3'd3;
  localparam logic [2:0] CFG_STEER_LIMIT    = 3'd4;
  localparam logic [2:0] CFG_STEER_DEADBAND = 3'd5;

  localparam logic [4:0]  RST_WINDOW_LENGTH  = 5'd8;
  localparam logic [14:0] RST_MAX_VELOCITY   = 15'd4096;
  localparam logic [14:0] RST_DUTY_LIMIT     = 15'd32767;
  localparam logic [14:0] RST_DUTY_DEADBAND  = 15'd0;
  localparam logic [15:0] RST_STEER_LIMIT    = 16'd65535;
  localparam logic [15:0] RST_STEER_DEADBAND = 16'd0;

  localparam logic [15:0] STEER_CENTRE = 16'd32768;
  localparam logic [14:0] DUTY_FULL    = 15'd32767;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACC,
    S_AVG_START,
    S_AVG_DIV,
    S_AVG_SAVE,
    S_DUTY_DIV,
    S_DUTY_OUT
  } mdsl_state_t;

  typedef struct packed {
    logic cmd_load;
    logic win_shift;
    logic acc_step;
    logic div_avg_start;
    logic div_duty_start;
    logic div_step;
    logic avg_load;
    logic out_load;
  } mdsl_cmd_t;

  typedef struct packed {
    logic acc_last;
    logic div_last;
    logic out_busy;
  } mdsl_stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/moving_average_duty_steering_limiter_unit.sv =====
// command: stored on acceptance; filter tick: the average is built in order from
//   L samples summed one per cycle, a start state, a 31-step serial divide and a save state
// publish tick: a 31-step serial divide, then the result goes into the output register
//   once no held result blocks it
// one word at a time; the next word is taken only once the unit is back in idle
// reset: synchronous active low; registers to defaults, window and average cleared at once
`default_nettype none
module moving_average_duty_steering_limiter_unit
  import mdsl_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_kind,
  input  wire logic [15:0] in_linear_velocity,
  input  wire logic [15:0] in_angular_rate,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_duty_cmd,
  output logic [15:0]      out_steering_position
);

  mdsl_cmd_t  cmd;
  mdsl_stat_t stat;

  mdsl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_kind),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  mdsl_dp u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_wr_en             (cfg_wr_en),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .in_linear_velocity    (in_linear_velocity),
    .in_angular_rate       (in_angular_rate),
    .cmd                   (cmd),
    .stat                  (stat),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_duty_cmd          (out_duty_cmd),
    .out_steering_position (out_steering_position)
  );

endmodule
`default_nettype wire

// ===== rtl/core/mdsl_ctrl.sv =====
`default_nettype none
module mdsl_ctrl
  import mdsl_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic [1:0] in_kind,
  output logic            in_stall,
  input  mdsl_stat_t      stat,
  output mdsl_cmd_t       cmd
);

  mdsl_state_t state_r, state_nxt;
  logic        in_acc;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_kind)
            KIND_CMD: begin
              cmd.cmd_load = 1'b1;
            end
            KIND_FILTER: begin
              cmd.win_shift = 1'b1;
              state_nxt     = S_ACC;
            end
            KIND_PUBLISH: begin
              cmd.div_duty_start = 1'b1;
              state_nxt          = S_DUTY_DIV;
            end
            default: ;
          endcase
        end
      end
      S_ACC: begin
        cmd.acc_step = 1'b1;
        if (stat.acc_last) begin
          state_nxt = S_AVG_START;
        end
      end
      S_AVG_START: begin
        cmd.div_avg_start = 1'b1;
        state_nxt         = S_AVG_DIV;
      end
      S_AVG_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = S_AVG_SAVE;
        end
      end
      S_AVG_SAVE: begin
        cmd.avg_load = 1'b1;
        state_nxt    = S_IDLE;
      end
      S_DUTY_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = S_DUTY_OUT;
        end
      end
      S_DUTY_OUT: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

`ifndef ASSERT_OFF
  a_filter_to_acc: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_kind == KIND_FILTER |=> state_r == S_ACC)
    else $error("filter tick did not start accumulation");

  a_publish_to_div: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_kind == KIND_PUBLISH |=> state_r == S_DUTY_DIV)
    else $error("publish tick did not start duty division");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !stat.out_busy)
    else $error("result register loaded while held");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/mdsl_dp.sv =====
`default_nettype none
module mdsl_dp
  import mdsl_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic [15:0] in_linear_velocity,
  input  wire logic [15:0] in_angular_rate,
  input  mdsl_cmd_t        cmd,
  output mdsl_stat_t       stat,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_duty_cmd,
  output logic [15:0]      out_steering_position
);

  // configuration
  logic [4:0]  win_len_r;
  logic [14:0] max_vel_r;
  logic [14:0] duty_lim_r;
  logic [14:0] duty_db_r;
  logic [15:0] steer_lim_r;
  logic [15:0] steer_db_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_len_r   <= RST_WINDOW_LENGTH;
      max_vel_r   <= RST_MAX_VELOCITY;
      duty_lim_r  <= RST_DUTY_LIMIT;
      duty_db_r   <= RST_DUTY_DEADBAND;
      steer_lim_r <= RST_STEER_LIMIT;
      steer_db_r  <= RST_STEER_DEADBAND;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_WINDOW_LENGTH:  win_len_r   <= cfg_data[4:0];
        CFG_MAX_VELOCITY:   max_vel_r   <= cfg_data[14:0];
        CFG_DUTY_LIMIT:     duty_lim_r  <= cfg_data[14:0];
        CFG_DUTY_DEADBAND:  duty_db_r   <= cfg_data[14:0];
        CFG_STEER_LIMIT:    steer_lim_r <= cfg_data;
        CFG_STEER_DEADBAND: steer_db_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // latest command
  logic [15:0] vel_r;
  logic [15:0] steer_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vel_r   <= '0;
      steer_r <= STEER_CENTRE;
    end else if (cmd.cmd_load) begin
      vel_r   <= in_linear_velocity;
      steer_r <= {~in_angular_rate[15], in_angular_rate[14:0]};
    end
  end

  // velocity window, newest at the top
  logic [15:0] win_r [MAX_WINDOW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < MAX_WINDOW; k++) begin
        win_r[k] <= '0;
      end
    end else if (cmd.win_shift) begin
      for (int k = 0; k < MAX_WINDOW - 1; k++) begin
        win_r[k] <= win_r[k+1];
      end
      win_r[MAX_WINDOW-1] <= vel_r;
    end
  end

  // effective length
  logic [LEN_W-1:0] eff_len;

  always_comb begin
    if (win_len_r == 5'd0) begin
      eff_len = LEN_W'(1);
    end else if (32'(win_len_r) > 32'(MAX_WINDOW)) begin
      eff_len = LEN_W'(MAX_WINDOW);
    end else begin
      eff_len = LEN_W'(win_len_r);
    end
  end

  // serial accumulation
  logic [WIN_IDX_W-1:0] acc_cnt_r, acc_cnt_nxt;
  logic [SUM_W-1:0]     sum_r, sum_nxt;
  logic [WIN_IDX_W-1:0] acc_idx;
  logic [15:0]          acc_word;

  assign acc_idx  = WIN_IDX_W'(MAX_WINDOW - 1) - acc_cnt_r;
  assign acc_word = win_r[acc_idx];
  assign stat.acc_last = (LEN_W'(acc_cnt_r) == eff_len - LEN_W'(1));

  always_comb begin
    acc_cnt_nxt = acc_cnt_r;
    sum_nxt     = sum_r;
    if (cmd.win_shift) begin
      acc_cnt_nxt = '0;
      sum_nxt     = '0;
    end else if (cmd.acc_step) begin
      acc_cnt_nxt = acc_cnt_r + WIN_IDX_W'(1);
      sum_nxt     = sum_r + {{(SUM_W-16){acc_word[15]}}, acc_word};
    end
  end

  always_ff @(posedge clk) begin
    acc_cnt_r <= acc_cnt_nxt;
    sum_r     <= sum_nxt;
  end

  // shared restoring divider
  logic [DIV_W-1:0]     q_r, q_nxt;
  logic [DVS_W-1:0]     rem_r, rem_nxt;
  logic [DVS_W-1:0]     dvs_r, dvs_nxt;
  logic [DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;
  logic                 neg_r, neg_nxt;
  logic [DVS_W:0]       rem_sh;
  logic [DVS_W:0]       rem_sub;
  logic [SUM_W-1:0]     sum_mag;
  logic [15:0]          avg_r;
  logic [15:0]          avg_mag;

  assign sum_mag = sum_r[SUM_W-1] ? -sum_r : sum_r;
  assign avg_mag = avg_r[15] ? -avg_r : avg_r;
  assign rem_sh  = {rem_r, q_r[DIV_W-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_r};
  assign stat.div_last = (div_cnt_r == DIV_CNT_W'(DIV_W - 1));

  always_comb begin
    q_nxt       = q_r;
    rem_nxt     = rem_r;
    dvs_nxt     = dvs_r;
    div_cnt_nxt = div_cnt_r;
    neg_nxt     = neg_r;
    if (cmd.div_avg_start) begin
      q_nxt       = DIV_W'(sum_mag);
      rem_nxt     = '0;
      dvs_nxt     = DVS_W'(eff_len);
      div_cnt_nxt = '0;
      neg_nxt     = sum_r[SUM_W-1];
    end else if (cmd.div_duty_start) begin
      q_nxt       = {avg_mag, 15'd0};
      rem_nxt     = '0;
      dvs_nxt     = (max_vel_r == '0) ? DVS_W'(1) : max_vel_r;
      div_cnt_nxt = '0;
      neg_nxt     = avg_r[15];
    end else if (cmd.div_step) begin
      div_cnt_nxt = div_cnt_r + DIV_CNT_W'(1);
      if (!rem_sub[DVS_W] || rem_sh[DVS_W]) begin
        rem_nxt = rem_sub[DVS_W-1:0];
        q_nxt   = {q_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[DVS_W-1:0];
        q_nxt   = {q_r[DIV_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r       <= q_nxt;
    rem_r     <= rem_nxt;
    dvs_r     <= dvs_nxt;
    div_cnt_r <= div_cnt_nxt;
    neg_r     <= neg_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avg_r <= '0;
    end else if (cmd.avg_load) begin
      avg_r <= neg_r ? -q_r[15:0] : q_r[15:0];
    end
  end

  // duty shaping
  logic [14:0] duty_q;
  logic [14:0] duty_m;
  logic [15:0] duty_s;

  always_comb begin
    duty_q = (|q_r[DIV_W-1:15]) ? DUTY_FULL : q_r[14:0];
    if (duty_q >= duty_lim_r) begin
      duty_m = duty_lim_r;
    end else if (duty_q >= duty_db_r) begin
      duty_m = duty_q;
    end else begin
      duty_m = '0;
    end
    duty_s = neg_r ? -{1'b0, duty_m} : {1'b0, duty_m};
  end

  // steering shaping
  logic [15:0] steer_dist;
  logic [15:0] steer_o;

  always_comb begin
    steer_dist = (steer_r >= STEER_CENTRE) ? steer_r - STEER_CENTRE
                                           : STEER_CENTRE - steer_r;
    if (steer_r >= steer_lim_r) begin
      steer_o = steer_lim_r;
    end else if (steer_dist >= steer_db_r) begin
      steer_o = steer_r;
    end else begin
      steer_o = STEER_CENTRE;
    end
  end

  // result register
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_duty_r;
  logic [15:0] out_steer_r;

  assign stat.out_busy = out_valid_r && out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_duty_r  <= duty_s;
      out_steer_r <= steer_o;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_duty_cmd          = out_duty_r;
  assign out_steering_position = out_steer_r;

endmodule
`default_nettype wire

// ===== test/mdsl_duty_steer_checker.sv =====
`timescale 1ns / 1ps
module mdsl_duty_steer_checker
  import mdsl_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [1:0]  in_kind,
  input  wire logic [15:0] in_linear_velocity,
  input  wire logic [15:0] in_angular_rate,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [15:0] out_duty_cmd,
  input  wire logic [15:0] out_steering_position,
  output int               fail_count,
  output int               pending
);

  typedef struct {
    logic [15:0] duty;
    logic [15:0] steer;
  } duty_steer_t;

  logic [4:0]         win_len;
  logic [14:0]        max_vel;
  logic [14:0]        duty_lim;
  logic [14:0]        duty_db;
  logic [15:0]        steer_lim;
  logic [15:0]        steer_db;

  logic signed [15:0] last_vel;
  logic [15:0]        last_steer;
  logic signed [15:0] vel_hist [MAX_WINDOW];
  logic signed [15:0] avg_vel;

  duty_steer_t        duty_steer_due [$];
  duty_steer_t        fresh;
  duty_steer_t        head;

  initial begin
    fail_count = 0;
    pending = 0;
  end

  function automatic void shift_in_velocity();
    int n;
    int acc;
    int mag;
    n = (win_len == '0) ? 1 : (int'(win_len) > MAX_WINDOW) ? MAX_WINDOW : int'(win_len);
    for (int i = 0; i < MAX_WINDOW - 1; i++) vel_hist[i] = vel_hist[i + 1];
    vel_hist[MAX_WINDOW - 1] = last_vel;
    acc = 0;
    for (int i = 0; i < n; i++) acc += vel_hist[MAX_WINDOW - 1 - i];
    mag = (acc < 0) ? -acc : acc;
    mag = mag / n;
    avg_vel = 16'((acc < 0) ? -mag : mag);
  endfunction

  function automatic logic [15:0] duty_for(input logic signed [15:0] a);
    longint mag;
    longint divisor;
    longint q;
    longint m;
    mag = (a < 0) ? -longint'(a) : longint'(a);
    divisor = (max_vel == '0) ? 1 : longint'(max_vel);
    q = (mag * 32768) / divisor;
    if (q > longint'(DUTY_FULL)) q = longint'(DUTY_FULL);
    if (q >= longint'(duty_lim)) m = longint'(duty_lim);
    else if (q >= longint'(duty_db)) m = q;
    else m = 0;
    return (a < 0) ? 16'(-m) : 16'(m);
  endfunction

  function automatic logic [15:0] steer_for(input logic [15:0] s);
    int gap;
    gap = (s >= STEER_CENTRE) ? int'(s) - int'(STEER_CENTRE) : int'(STEER_CENTRE) - int'(s);
    if (s >= steer_lim) return steer_lim;
    if (gap >= int'(steer_db)) return s;
    return STEER_CENTRE;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      win_len = RST_WINDOW_LENGTH;
      max_vel = RST_MAX_VELOCITY;
      duty_lim = RST_DUTY_LIMIT;
      duty_db = RST_DUTY_DEADBAND;
      steer_lim = RST_STEER_LIMIT;
      steer_db = RST_STEER_DEADBAND;
      last_vel = '0;
      last_steer = STEER_CENTRE;
      foreach (vel_hist[i]) vel_hist[i] = '0;
      avg_vel = '0;
      duty_steer_due.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_WINDOW_LENGTH:  win_len = cfg_data[4:0];
          CFG_MAX_VELOCITY:   max_vel = cfg_data[14:0];
          CFG_DUTY_LIMIT:     duty_lim = cfg_data[14:0];
          CFG_DUTY_DEADBAND:  duty_db = cfg_data[14:0];
          CFG_STEER_LIMIT:    steer_lim = cfg_data;
          CFG_STEER_DEADBAND: steer_db = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        case (in_kind)
          KIND_CMD: begin
            last_vel = in_linear_velocity;
            last_steer = in_angular_rate + STEER_CENTRE;
          end
          KIND_FILTER: shift_in_velocity();
          KIND_PUBLISH: begin
            fresh.duty = duty_for(avg_vel);
            fresh.steer = steer_for(last_steer);
            duty_steer_due.push_back(fresh);
          end
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (duty_steer_due.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result word: expected none, got duty %0d steering %0d",
                   $time, $signed(out_duty_cmd), out_steering_position);
        end else begin
          head = duty_steer_due.pop_front();
          if (out_duty_cmd !== head.duty) begin
            fail_count++;
            $display("%0t: duty expected %0d, got %0d",
                     $time, $signed(head.duty), $signed(out_duty_cmd));
          end
          if (out_steering_position !== head.steer) begin
            fail_count++;
            $display("%0t: steering_position expected %0d, got %0d",
                     $time, head.steer, out_steering_position);
          end
        end
      end
    end
    pending = duty_steer_due.size();
  end

endmodule

// ===== test/moving_average_duty_steering_limiter_unit_tb.sv =====
`timescale 1ns / 1ps
module moving_average_duty_steering_limiter_unit_tb;
  import mdsl_pkg::*;

  localparam int CLK_PERIOD      = 20;
  localparam int RESET_CYCLES    = 9;
  localparam int SETTLE_CYCLES   = 80;
  localparam int CYCLE_LIMIT     = 500000;
  localparam int NUM_PHASES      = 10;
  localparam int ITEMS_PER_PHASE = 108;
  localparam int QUIET_PHASE     = 3;
  localparam int HOLD_PHASE      = 5;
  localparam int HOLD_CYCLES     = 400;

  localparam logic [1:0] KIND_SPARE     = 2'd3;
  localparam logic [2:0] CFG_UNMAPPED_A = 3'd6;
  localparam logic [2:0] CFG_UNMAPPED_B = 3'd7;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_kind = '0;
  logic [15:0] in_linear_velocity = '0;
  logic [15:0] in_angular_rate = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_duty_cmd;
  logic [15:0] out_steering_position;

  int          pending;
  int          fail_count;
  int          cycle_count = 0;
  logic        idle_en = 1'b1;
  logic        hold_go = 1'b0;
  logic        hold_done = 1'b0;
  int          hold_left = 0;
  logic [14:0] cur_max_vel = RST_MAX_VELOCITY;

  always #(CLK_PERIOD / 2) clk = ~clk;

  moving_average_duty_steering_limiter_unit u_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_wr_en             (cfg_wr_en),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_kind               (in_kind),
    .in_linear_velocity    (in_linear_velocity),
    .in_angular_rate       (in_angular_rate),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_duty_cmd          (out_duty_cmd),
    .out_steering_position (out_steering_position)
  );

  mdsl_duty_steer_checker u_check (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_wr_en             (cfg_wr_en),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_kind               (in_kind),
    .in_linear_velocity    (in_linear_velocity),
    .in_angular_rate       (in_angular_rate),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_duty_cmd          (out_duty_cmd),
    .out_steering_position (out_steering_position),
    .fail_count            (fail_count),
    .pending               (pending)
  );

  // result side: random stalls, plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_go && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= idle_en && ($urandom_range(99) < 35);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: timeout after %0d cycles, %0d results outstanding",
             $time, cycle_count, pending);
    $display("Simulation FAILED");
    $finish;
  end

  function automatic logic [15:0] pick_velocity();
    int span;
    span = int'(cur_max_vel);
    case ($urandom_range(9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3, 4, 5: return 16'(int'($urandom_range(2 * span)) - span);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_angle();
    case ($urandom_range(7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3, 4: return 16'(int'($urandom_range(2048)) - 1024);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_word(input logic [1:0] kind, input logic [15:0] vel,
                           input logic [15:0] ang);
    @(negedge clk);
    while (idle_en && ($urandom_range(99) < 35)) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_linear_velocity <= vel;
    in_angular_rate <= ang;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // mostly command, filter ticks, publish; the rest loose words of any kind
  task automatic send_burst(inout int sent);
    int n;
    logic [1:0] kind;
    if ($urandom_range(99) < 80) begin
      send_word(KIND_CMD, pick_velocity(), pick_angle());
      n = $urandom_range(1, 4);
      repeat (n) send_word(KIND_FILTER, 16'($urandom), 16'($urandom));
      send_word(KIND_PUBLISH, 16'($urandom), 16'($urandom));
      sent += n + 2;
    end else begin
      n = $urandom_range(1, 3);
      repeat (n) begin
        kind = 2'($urandom_range(3));
        send_word(kind, pick_velocity(), pick_angle());
        if (kind != KIND_SPARE) sent++;
      end
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val,
                           input logic [15:0] keep);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= (val & keep) | (16'($urandom) & ~keep);
  endtask

  task automatic program_phase(input int ph);
    logic [15:0] val [6];
    case (ph)
      0: val = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
      1: val = '{16'd31, 16'd32767, 16'd32767, 16'd32767, 16'd65535, 16'd65535};
      2: val = '{16'd1, 16'd1, 16'd16384, 16'd100, 16'd40000, 16'd32768};
      3: val = '{16'd16, 16'd4096, 16'd20000, 16'd2000, 16'd50000, 16'd1000};
      4: val = '{16'd17, 16'd8192, 16'd32767, 16'd0, 16'd65535, 16'd0};
      default: begin
        val[0] = ($urandom_range(99) < 85) ? 16'($urandom_range(1, 16))
                                           : 16'($urandom_range(31));
        case ($urandom_range(2))
          0: val[1] = 16'($urandom_range(1, 64));
          1: val[1] = 16'd4096;
          default: val[1] = 16'($urandom_range(1, 32767));
        endcase
        val[2] = ($urandom_range(3) == 0) ? 16'd32767 : 16'($urandom_range(32767));
        val[3] = ($urandom_range(3) == 0) ? 16'($urandom_range(32767))
                                          : 16'($urandom_range(val[2]));
        val[4] = ($urandom_range(3) == 0) ? 16'($urandom)
                                          : 16'($urandom_range(32768, 65535));
        val[5] = 16'($urandom_range(32768));
      end
    endcase
    cur_max_vel = val[1][14:0];
    write_reg(CFG_WINDOW_LENGTH, val[0], 16'h001F);
    write_reg(CFG_MAX_VELOCITY, val[1], 16'h7FFF);
    write_reg(CFG_DUTY_LIMIT, val[2], 16'h7FFF);
    write_reg(CFG_DUTY_DEADBAND, val[3], 16'h7FFF);
    write_reg(CFG_STEER_LIMIT, val[4], 16'hFFFF);
    write_reg(CFG_STEER_DEADBAND, val[5], 16'hFFFF);
    write_reg(($urandom_range(1) == 0) ? CFG_UNMAPPED_A : CFG_UNMAPPED_B,
              16'($urandom), 16'h0000);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    int sent;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset state, ignored kind, then both velocity and steering extremes
    send_word(KIND_PUBLISH, 16'hFFFF, 16'hFFFF);
    send_word(KIND_SPARE, 16'h7FFF, 16'h8000);
    send_word(KIND_PUBLISH, 16'h0000, 16'h0000);
    send_word(KIND_CMD, 16'h7FFF, 16'h7FFF);
    send_word(KIND_FILTER, 16'h0000, 16'h0000);
    send_word(KIND_PUBLISH, 16'h0000, 16'h0000);
    send_word(KIND_CMD, 16'h8000, 16'h8000);
    repeat (MAX_WINDOW) send_word(KIND_FILTER, 16'hFFFF, 16'hFFFF);
    send_word(KIND_PUBLISH, 16'hFFFF, 16'hFFFF);
    send_word(KIND_CMD, 16'h0000, 16'h0000);
    send_word(KIND_PUBLISH, 16'h0000, 16'h0000);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_drained();
      program_phase(ph);
      @(posedge clk);
      idle_en = (ph != QUIET_PHASE);
      if (ph == HOLD_PHASE) hold_go = 1'b1;
      // average must still reflect the old window length
      send_word(KIND_PUBLISH, 16'($urandom), 16'($urandom));
      sent = 1;
      while (sent < ITEMS_PER_PHASE) send_burst(sent);
    end

    wait_drained();
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
